[rtl/core/pdsc_pkg.sv]
// Shared types, register indexes and helper functions for the PD steering controller.
package pdsc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CORRECTION_LIMIT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CORNER_THRESHOLD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CORNER_PERCENT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPIN_SPEED       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SLEW_STEP        = 3'd6;

    // Transaction codes
    localparam logic       KIND_CLEAR = 1'b1;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // Register reset values
    localparam logic [14:0] CORRECTION_LIMIT_RST = 15'd32767;
    localparam logic [6:0]  CORNER_PERCENT_RST   = 7'd100;

    // Wheel command limit
    localparam logic signed [17:0] WHEEL_MAX = 18'sd32767;

    // x / 100 for x < 2**23: (x * ceil(2**30 / 100)) >> 30
    localparam int              DIV100_SHIFT = 30;
    localparam logic [23:0]     DIV100_MUL   = 24'd10737419;

    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] deriv_gain;
        logic [14:0]        correction_limit;
        logic [14:0]        corner_threshold;
        logic [6:0]         corner_speed_percent;
        logic [14:0]        spin_speed;
        logic [14:0]        slew_step;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic               line_found;
        logic signed [15:0] line_error;
        logic [1:0]         lost_side;
        logic signed [15:0] cruise_speed;
    } in_t;

    typedef struct packed {
        logic signed [15:0] left_cmd;
        logic signed [15:0] right_cmd;
        logic signed [15:0] steer_amount;
        logic               searching;
    } out_t;

    // Input register contents: the sensor fields plus the state-free products
    typedef struct packed {
        logic               kind;
        logic               line_found;
        logic [1:0]         lost_side;
        logic signed [15:0] line_error;
        logic signed [15:0] cruise_speed;
        logic signed [31:0] p_prod;
        logic               slow;
        logic               spd_neg;
        logic [22:0]        spd_mag;
    } pre_t;

    // Move cur toward tgt by at most step; step zero jumps to the target
    function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [14:0]        step);
        logic signed [17:0] cur_w;
        logic signed [17:0] tgt_w;
        logic signed [17:0] stp_w;
        logic signed [17:0] up;
        logic signed [17:0] dn;
        logic signed [15:0] res;
        cur_w = 18'(cur);
        tgt_w = 18'(tgt);
        stp_w = $signed({3'b000, step});
        up    = cur_w + stp_w;
        dn    = cur_w - stp_w;
        if (step == 15'd0) begin
            res = tgt;
        end else if (cur_w < tgt_w) begin
            res = (up > tgt_w) ? tgt : up[15:0];
        end else if (cur_w > tgt_w) begin
            res = (dn < tgt_w) ? tgt : dn[15:0];
        end else begin
            res = cur;
        end
        return res;
    endfunction

    // Symmetric clamp of an 18 bit value to +/- WHEEL_MAX
    function automatic logic signed [15:0] wheel_clamp(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > WHEEL_MAX) begin
            res = WHEEL_MAX[15:0];
        end else if (v < -WHEEL_MAX) begin
            res = 16'(-WHEEL_MAX);
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/pdsc_in_stage.sv]
// Input register of the PD steering controller, with the state-free products.
module pdsc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdsc_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  pdsc_pkg::in_t     s_data,
    output logic              pre_valid,
    input  logic              pre_ready,
    output pdsc_pkg::pre_t    pre
);

    logic             valid_reg;
    pdsc_pkg::pre_t   pre_reg;
    pdsc_pkg::pre_t   pre_next;
    logic [15:0]      err_mag;
    logic [15:0]      base_mag;

    assign s_ready = !valid_reg || pre_ready;

    // exact magnitudes: -32768 gives 32768
    assign err_mag  = s_data.line_error[15] ? 16'(~s_data.line_error + 16'd1)
                                            : s_data.line_error;
    assign base_mag = s_data.cruise_speed[15] ? 16'(~s_data.cruise_speed + 16'd1)
                                              : s_data.cruise_speed;

    always_comb begin
        pre_next.kind         = s_data.kind;
        pre_next.line_found   = s_data.line_found;
        pre_next.lost_side    = s_data.lost_side;
        pre_next.line_error   = s_data.line_error;
        pre_next.cruise_speed = s_data.cruise_speed;
        pre_next.p_prod       = cfg.prop_gain * s_data.line_error;
        pre_next.slow         = (cfg.corner_threshold != 15'd0) &&
                                (err_mag > {1'b0, cfg.corner_threshold});
        pre_next.spd_neg      = s_data.cruise_speed[15];
        pre_next.spd_mag      = base_mag * cfg.corner_speed_percent;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pre_reg <= pre_next;
        end
    end

    assign pre_valid = valid_reg;
    assign pre       = pre_reg;

endmodule

[rtl/core/pdsc_out_stage.sv]
// Controller state, PD law, wheel targets, slew limiting and the result register.
module pdsc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdsc_pkg::cfg_t    cfg,
    input  logic              pre_valid,
    output logic              pre_ready,
    input  pdsc_pkg::pre_t    pre,
    output logic              m_valid,
    input  logic              m_ready,
    output pdsc_pkg::out_t    m_data
);

    logic               out_valid_reg;
    pdsc_pkg::out_t     out_reg;
    pdsc_pkg::out_t     out_next;
    logic signed [15:0] prev_error_reg;
    logic               prev_valid_reg;
    logic signed [15:0] left_now_reg;
    logic signed [15:0] right_now_reg;
    logic signed [15:0] left_now_next;
    logic signed [15:0] right_now_next;

    logic               take;
    logic signed [16:0] deriv;
    logic signed [32:0] d_prod;
    logic signed [33:0] raw;
    logic signed [33:0] lim_pos;
    logic signed [15:0] corr;
    logic [46:0]        q_prod;
    logic [15:0]        q_mag;
    logic signed [17:0] speed;
    logic signed [15:0] sspd;
    logic signed [16:0] base_rnd;
    logic signed [16:0] half_w;
    logic signed [15:0] tgt_l;
    logic signed [15:0] tgt_r;

    assign pre_ready = !out_valid_reg || m_ready;
    assign take      = pre_valid && pre_ready;

    // PD correction
    assign deriv   = prev_valid_reg ? (17'(pre.line_error) - 17'(prev_error_reg)) : 17'sd0;
    assign d_prod  = cfg.deriv_gain * deriv;
    assign raw     = 34'(pre.p_prod) + 34'(d_prod);
    assign lim_pos = $signed({19'd0, cfg.correction_limit});

    always_comb begin
        if (raw > lim_pos) begin
            corr = lim_pos[15:0];
        end else if (raw < -lim_pos) begin
            corr = 16'(-lim_pos);
        end else begin
            corr = raw[15:0];
        end
    end

    // Corner slowing, truncated toward zero through the magnitude
    assign q_prod = pre.spd_mag * pdsc_pkg::DIV100_MUL;
    assign q_mag  = q_prod[pdsc_pkg::DIV100_SHIFT+15:pdsc_pkg::DIV100_SHIFT];

    always_comb begin
        if (pre.slow) begin
            speed = pre.spd_neg ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
        end else begin
            speed = 18'(pre.cruise_speed);
        end
    end

    // Search targets
    assign sspd     = $signed({1'b0, cfg.spin_speed});
    assign base_rnd = 17'(pre.cruise_speed) + $signed({16'd0, pre.cruise_speed[15]});
    assign half_w   = base_rnd >>> 1;

    always_comb begin
        if (pre.line_found) begin
            tgt_l = pdsc_pkg::wheel_clamp(speed + 18'(corr));
            tgt_r = pdsc_pkg::wheel_clamp(speed - 18'(corr));
        end else if (pre.lost_side == pdsc_pkg::SIDE_LEFT) begin
            tgt_l = -sspd;
            tgt_r = sspd;
        end else if (pre.lost_side == pdsc_pkg::SIDE_RIGHT) begin
            tgt_l = sspd;
            tgt_r = -sspd;
        end else begin
            tgt_l = half_w[15:0];
            tgt_r = half_w[15:0];
        end
    end

    always_comb begin
        if (pre.kind == pdsc_pkg::KIND_CLEAR) begin
            left_now_next         = 16'sd0;
            right_now_next        = 16'sd0;
            out_next.steer_amount = 16'sd0;
            out_next.searching    = 1'b0;
        end else begin
            left_now_next         = pdsc_pkg::slew(left_now_reg, tgt_l, cfg.slew_step);
            right_now_next        = pdsc_pkg::slew(right_now_reg, tgt_r, cfg.slew_step);
            out_next.steer_amount = pre.line_found ? corr : 16'sd0;
            out_next.searching    = !pre.line_found;
        end
        out_next.left_cmd  = left_now_next;
        out_next.right_cmd = right_now_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            prev_error_reg <= 16'sd0;
            prev_valid_reg <= 1'b0;
            left_now_reg   <= 16'sd0;
            right_now_reg  <= 16'sd0;
        end else begin
            if (pre_ready) begin
                out_valid_reg <= pre_valid;
            end
            if (take) begin
                left_now_reg  <= left_now_next;
                right_now_reg <= right_now_next;
                if (pre.kind == pdsc_pkg::KIND_CLEAR) begin
                    prev_error_reg <= 16'sd0;
                    prev_valid_reg <= 1'b0;
                end else if (pre.line_found) begin
                    prev_error_reg <= pre.line_error;
                    prev_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_clear_state: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (pre.kind == pdsc_pkg::KIND_CLEAR) |=>
            !prev_valid_reg && (left_now_reg == 16'sd0) && (right_now_reg == 16'sd0))
        else $error("clear transaction left controller state set");

    a_cmd_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.left_cmd == left_now_reg) && (m_data.right_cmd == right_now_reg))
        else $error("result commands differ from ramped state");

    a_search_no_steer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.searching |-> (m_data.steer_amount == 16'sd0))
        else $error("steering correction while searching");

    a_steer_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (18'(m_data.steer_amount) <= $signed({3'b000, cfg.correction_limit}))
            && (18'(m_data.steer_amount) >= -$signed({3'b000, cfg.correction_limit})))
        else $error("steering correction outside its limit");

endmodule

[rtl/core/pd_steering_controller_with_ramp.sv]
// Top level of the PD steering controller with slew-limited wheel commands.
// A transaction accepted into the input register moves on to the result register, which
// raises m_valid; a result that is not taken holds it in the input register.
// Throughput: one transaction per cycle; the input register and the result register stall
// together only when the result is not taken.
// The state loop (previous error, ramped wheel commands) closes within the out stage.
// Reset (aresetn low, synchronous): registers to defaults, controller state cleared, no result.
module pd_steering_controller_with_ramp (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes; the user must write only while idle, the block does not enforce it
    input  logic                                cfg_wr_en,
    input  logic [pdsc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pdsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // sensor transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pdsc_pkg::in_t                       s_data,
    // wheel command transactions
    output logic                                m_valid,
    input  logic                                m_ready,
    output pdsc_pkg::out_t                      m_data
);

    pdsc_pkg::cfg_t cfg_reg;
    pdsc_pkg::pre_t pre;
    logic           pre_valid;
    logic           pre_ready;

    // Configuration registers; indexes beyond the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain            <= 16'sd0;
            cfg_reg.deriv_gain           <= 16'sd0;
            cfg_reg.correction_limit     <= pdsc_pkg::CORRECTION_LIMIT_RST;
            cfg_reg.corner_threshold     <= 15'd0;
            cfg_reg.corner_speed_percent <= pdsc_pkg::CORNER_PERCENT_RST;
            cfg_reg.spin_speed           <= 15'd0;
            cfg_reg.slew_step            <= 15'd0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pdsc_pkg::REG_PROP_GAIN: begin
                    cfg_reg.prop_gain <= $signed(cfg_wdata);
                end
                pdsc_pkg::REG_DERIV_GAIN: begin
                    cfg_reg.deriv_gain <= $signed(cfg_wdata);
                end
                pdsc_pkg::REG_CORRECTION_LIMIT: begin
                    cfg_reg.correction_limit <= cfg_wdata[14:0];
                end
                pdsc_pkg::REG_CORNER_THRESHOLD: begin
                    cfg_reg.corner_threshold <= cfg_wdata[14:0];
                end
                pdsc_pkg::REG_CORNER_PERCENT: begin
                    cfg_reg.corner_speed_percent <= cfg_wdata[6:0];
                end
                pdsc_pkg::REG_SPIN_SPEED: begin
                    cfg_reg.spin_speed <= cfg_wdata[14:0];
                end
                pdsc_pkg::REG_SLEW_STEP: begin
                    cfg_reg.slew_step <= cfg_wdata[14:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1: register the transaction, form prop_gain*error and the corner speed product
    pdsc_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .pre_valid (pre_valid),
        .pre_ready (pre_ready),
        .pre       (pre)
    );

    // Stage 2: derivative term, clamps, targets and ramp, into the result register
    pdsc_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pre_valid (pre_valid),
        .pre_ready (pre_ready),
        .pre       (pre),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[test/pdsc_wheel_checker.sv]
// Scoreboard for the PD steering controller: predicts every wheel command transaction and compares.
module pdsc_wheel_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pdsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pdsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  pdsc_pkg::in_t                   s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  pdsc_pkg::out_t                  m_data,
    output int                              fail_count,
    output int                              pending
);

    localparam int REPORT_MAX = 10;

    pdsc_pkg::cfg_t regs;
    longint         prev_err;
    bit             prev_seen;
    longint         left_wheel;
    longint         right_wheel;
    pdsc_pkg::out_t wheel_cmds_due[$];
    pdsc_pkg::out_t due;
    int             mismatches  = 0;
    int             results_seen = 0;

    function automatic longint bound(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Slew limit on one wheel; a zero step jumps straight to the target
    function automatic longint ramp_toward(input longint cur, input longint tgt);
        longint stepw;
        stepw = longint'(regs.slew_step);
        if (stepw == 0) return tgt;
        if (cur < tgt) return (cur + stepw > tgt) ? tgt : cur + stepw;
        if (cur > tgt) return (cur - stepw < tgt) ? tgt : cur - stepw;
        return cur;
    endfunction

    // Wide-arithmetic controller step; updates the shadow state
    function automatic pdsc_pkg::out_t advance_controller(input pdsc_pkg::in_t r);
        pdsc_pkg::out_t res;
        longint err;
        longint base;
        longint lim;
        longint wheel_lim;
        longint spin;
        longint raw;
        longint speed;
        longint corr;
        longint tl;
        longint tr;
        err       = longint'($signed(r.line_error));
        base      = longint'($signed(r.cruise_speed));
        lim       = longint'(regs.correction_limit);
        wheel_lim = longint'(pdsc_pkg::WHEEL_MAX);
        spin      = longint'(regs.spin_speed);
        corr      = 0;
        res       = '0;
        if (r.kind == pdsc_pkg::KIND_CLEAR) begin
            prev_err    = 0;
            prev_seen   = 1'b0;
            left_wheel  = 0;
            right_wheel = 0;
            return res;
        end
        if (r.line_found) begin
            raw = longint'($signed(regs.prop_gain)) * err;
            if (prev_seen) raw += longint'($signed(regs.deriv_gain)) * (err - prev_err);
            corr  = bound(raw, -lim, lim);
            speed = base;
            if (regs.corner_threshold != 0 &&
                (err < 0 ? -err : err) > longint'(regs.corner_threshold)) begin
                speed = (base * longint'(regs.corner_speed_percent)) / 100;
            end
            tl        = bound(speed + corr, -wheel_lim, wheel_lim);
            tr        = bound(speed - corr, -wheel_lim, wheel_lim);
            prev_err  = err;
            prev_seen = 1'b1;
        end else begin
            res.searching = 1'b1;
            if (r.lost_side == pdsc_pkg::SIDE_LEFT) begin
                tl = -spin;
                tr = spin;
            end else if (r.lost_side == pdsc_pkg::SIDE_RIGHT) begin
                tl = spin;
                tr = -spin;
            end else begin
                tl = base / 2;
                tr = tl;
            end
        end
        left_wheel        = ramp_toward(left_wheel, tl);
        right_wheel       = ramp_toward(right_wheel, tr);
        res.left_cmd      = 16'(left_wheel);
        res.right_cmd     = 16'(right_wheel);
        res.steer_amount  = 16'(corr);
        return res;
    endfunction

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch in transaction %0d, %s: expected %0d, got %0d",
                         results_seen, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs                      = '0;
            regs.correction_limit     = pdsc_pkg::CORRECTION_LIMIT_RST;
            regs.corner_speed_percent = pdsc_pkg::CORNER_PERCENT_RST;
            prev_err                  = 0;
            prev_seen                 = 1'b0;
            left_wheel                = 0;
            right_wheel               = 0;
            wheel_cmds_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    pdsc_pkg::REG_PROP_GAIN:        regs.prop_gain        = cfg_wdata;
                    pdsc_pkg::REG_DERIV_GAIN:       regs.deriv_gain       = cfg_wdata;
                    pdsc_pkg::REG_CORRECTION_LIMIT: regs.correction_limit = cfg_wdata[14:0];
                    pdsc_pkg::REG_CORNER_THRESHOLD: regs.corner_threshold = cfg_wdata[14:0];
                    pdsc_pkg::REG_CORNER_PERCENT:
                        regs.corner_speed_percent = cfg_wdata[6:0];
                    pdsc_pkg::REG_SPIN_SPEED:       regs.spin_speed       = cfg_wdata[14:0];
                    pdsc_pkg::REG_SLEW_STEP:        regs.slew_step        = cfg_wdata[14:0];
                    default: ;
                endcase
            end
            // results leave before the new transaction is predicted
            if (m_valid && m_ready) begin
                results_seen++;
                if (wheel_cmds_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result transaction %0d: %0d %0d %0d %0d",
                                 results_seen, m_data.left_cmd, m_data.right_cmd,
                                 m_data.steer_amount, m_data.searching);
                end else begin
                    due = wheel_cmds_due.pop_front();
                    check_field("left_cmd", due.left_cmd, m_data.left_cmd);
                    check_field("right_cmd", due.right_cmd, m_data.right_cmd);
                    check_field("steer_amount", due.steer_amount, m_data.steer_amount);
                    check_field("searching", {15'd0, due.searching},
                                {15'd0, m_data.searching});
                end
            end
            if (s_valid && s_ready) wheel_cmds_due.push_back(advance_controller(s_data));
        end
        fail_count <= mismatches;
        pending    <= wheel_cmds_due.size();
    end

endmodule

[test/testbench.sv]
// Top of the PD steering controller testbench: clock, reset, stimulus and verdict.
module testbench;

    // kind and side codes that the package leaves unnamed
    localparam logic       KIND_STEP    = 1'b0;
    localparam logic [1:0] SIDE_UNKNOWN = 2'd0;
    localparam logic [1:0] SIDE_UNDEF   = 2'd3;

    localparam int ITEMS_PER_PHASE = 315;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RUN_LIMIT       = 2000000;

    logic                            aclk    = 1'b0;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [pdsc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [pdsc_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    pdsc_pkg::in_t                   s_data;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    pdsc_pkg::out_t                  m_data;
    int                              fail_count;
    int                              pending;

    // idling percentages, changed between phases
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    // long receiver hold-off: stimulus raises a request, receiver process serves it
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    logic signed [15:0] drift_err = '0;
    int                 sent      = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pd_steering_controller_with_ramp u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    pdsc_wheel_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    // While held, the block's two register stages fill and s_ready drops.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    function automatic pdsc_pkg::in_t reading(input logic kind, input logic found,
                                              input logic signed [15:0] err,
                                              input logic [1:0] side,
                                              input logic signed [15:0] base);
        pdsc_pkg::in_t r;
        r.kind         = kind;
        r.line_found   = found;
        r.line_error   = err;
        r.lost_side    = side;
        r.cruise_speed = base;
        return r;
    endfunction

    // Mostly a tracked line, often with a drifting error, so the derivative term sees
    // realistic sequences; the rest is extremes, full-range noise, losses and clears.
    function automatic pdsc_pkg::in_t random_reading();
        pdsc_pkg::in_t r;
        int            roll;
        roll         = $urandom_range(99);
        r.kind       = (roll < 3) ? pdsc_pkg::KIND_CLEAR : KIND_STEP;
        r.line_found = (roll >= 28);
        r.lost_side  = 2'($urandom_range(3));
        case ($urandom_range(9))
            0, 1, 2, 3: r.line_error = 16'(int'(drift_err) + int'($urandom_range(600)) - 300);
            4, 5:       r.line_error = 16'($urandom);
            6:          r.line_error = 16'sh7fff;
            7:          r.line_error = 16'sh8000;
            8:          r.line_error = 16'(int'($urandom_range(40000)) - 20000);
            default:    r.line_error = '0;
        endcase
        case ($urandom_range(5))
            0, 1, 2: r.cruise_speed = 16'(int'($urandom_range(16000)) - 4000);
            3:       r.cruise_speed = 16'($urandom);
            4:       r.cruise_speed = 16'sh7fff;
            default: r.cruise_speed = 16'sh8000;
        endcase
        if (r.line_found) drift_err = r.line_error;
        return r;
    endfunction

    function automatic pdsc_pkg::cfg_t phase_settings(input int p);
        pdsc_pkg::cfg_t c;
        c.prop_gain            = 16'(int'($urandom_range(64)) - 32);
        c.deriv_gain           = 16'(int'($urandom_range(64)) - 32);
        if ($urandom_range(3) == 0) c.prop_gain  = 16'($urandom);
        if ($urandom_range(3) == 0) c.deriv_gain = 16'($urandom);
        c.correction_limit     = 15'($urandom_range(32767));
        c.corner_threshold     = 15'($urandom_range(20000));
        c.corner_speed_percent = 7'($urandom_range(127));
        c.spin_speed           = 15'($urandom);
        c.slew_step            = 15'($urandom_range(8000));
        case (p)
            1: begin    // all at the top but corner_threshold, set to 1
                c.prop_gain            = 16'sh7fff;
                c.deriv_gain           = 16'sh7fff;
                c.correction_limit     = 15'h7fff;
                c.corner_threshold     = 15'd1;
                c.corner_speed_percent = 7'h7f;
                c.spin_speed           = 15'h7fff;
                c.slew_step            = 15'h7fff;
            end
            2: begin    // all at the bottom but corner_threshold, set to its top
                c.prop_gain            = 16'sh8000;
                c.deriv_gain           = 16'sh8000;
                c.correction_limit     = '0;
                c.corner_threshold     = 15'h7fff;
                c.corner_speed_percent = '0;
                c.spin_speed           = '0;
                c.slew_step            = '0;
            end
            5: c.slew_step = 15'd1;     // slowest possible slew
            default: ;
        endcase
        return c;
    endfunction

    // Write all seven registers on consecutive edges; enable drops once at the end
    task automatic load_settings(input pdsc_pkg::cfg_t c);
        logic [pdsc_pkg::CFG_ADDR_W-1:0] idx [7];
        logic [pdsc_pkg::CFG_DATA_W-1:0] val [7];
        idx[0] = pdsc_pkg::REG_PROP_GAIN;        val[0] = c.prop_gain;
        idx[1] = pdsc_pkg::REG_DERIV_GAIN;       val[1] = c.deriv_gain;
        idx[2] = pdsc_pkg::REG_CORRECTION_LIMIT; val[2] = 16'(c.correction_limit);
        idx[3] = pdsc_pkg::REG_CORNER_THRESHOLD; val[3] = 16'(c.corner_threshold);
        idx[4] = pdsc_pkg::REG_CORNER_PERCENT;   val[4] = 16'(c.corner_speed_percent);
        idx[5] = pdsc_pkg::REG_SPIN_SPEED;       val[5] = 16'(c.spin_speed);
        idx[6] = pdsc_pkg::REG_SLEW_STEP;        val[6] = 16'(c.slew_step);
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one sensor transaction. Valid is only lowered when a gap is taken,
    // so back-to-back transactions never see a low-then-high in one step.
    task automatic send_reading(input pdsc_pkg::in_t r);
        int gap;
        gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // Quiesce the input and wait until every predicted result has been taken
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        pdsc_pkg::cfg_t dir_cfg;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first idling pattern: sender idles lightly, receiver stalls heavily
        snd_idle_pct  = 19;
        rcv_stall_pct = 57;

        // reset defaults: zero gains, so no correction
        send_reading(reading(KIND_STEP, 1'b1, 16'sd500, SIDE_UNKNOWN, 16'sd2000));
        send_reading(reading(KIND_STEP, 1'b0, 16'sd0, SIDE_UNKNOWN, -16'sd3));
        settle();

        dir_cfg.prop_gain            = 16'sd4;
        dir_cfg.deriv_gain           = -16'sd3;
        dir_cfg.correction_limit     = 15'd2000;
        dir_cfg.corner_threshold     = 15'd6000;
        dir_cfg.corner_speed_percent = 7'd50;
        dir_cfg.spin_speed           = 15'd1500;
        dir_cfg.slew_step            = '0;
        load_settings(dir_cfg);

        // the derivative is taken against the tracked error of the previous step
        send_reading(reading(KIND_STEP, 1'b1, 16'sd0, SIDE_UNKNOWN, 16'sd1000));
        send_reading(reading(KIND_STEP, 1'b1, 16'sd300, pdsc_pkg::SIDE_LEFT, 16'sd1000));
        send_reading(reading(KIND_STEP, 1'b1, -16'sd300, pdsc_pkg::SIDE_RIGHT, 16'sd1000));
        // cornering, including truncation of a negative speed
        send_reading(reading(KIND_STEP, 1'b1, 16'sd7000, SIDE_UNKNOWN, 16'sd8000));
        send_reading(reading(KIND_STEP, 1'b1, -16'sd7000, SIDE_UNKNOWN, -16'sd8001));
        // field extremes; the most negative error has magnitude 32768
        send_reading(reading(KIND_STEP, 1'b1, 16'sh7fff, SIDE_UNDEF, 16'sh7fff));
        send_reading(reading(KIND_STEP, 1'b1, 16'sh8000, SIDE_UNDEF, 16'sh8000));
        // line lost: spin to each side, half speed when the side is unknown or undefined
        send_reading(reading(KIND_STEP, 1'b0, 16'sd0, pdsc_pkg::SIDE_LEFT, 16'sd4000));
        send_reading(reading(KIND_STEP, 1'b0, 16'sh7fff, pdsc_pkg::SIDE_RIGHT, 16'sd4000));
        send_reading(reading(KIND_STEP, 1'b0, 16'sd0, SIDE_UNKNOWN, -16'sd32767));
        send_reading(reading(KIND_STEP, 1'b0, 16'sd0, SIDE_UNDEF, 16'sh7fff));
        send_reading(reading(KIND_STEP, 1'b0, 16'sd0, SIDE_UNKNOWN, 16'sh8000));
        // a tracked step after the losses uses the last tracked error for the derivative
        send_reading(reading(KIND_STEP, 1'b1, 16'sd50, pdsc_pkg::SIDE_LEFT, 16'sd0));
        // clear, then derivative suppressed again
        send_reading(reading(pdsc_pkg::KIND_CLEAR, 1'b1, 16'sh7fff, SIDE_UNDEF, 16'sh7fff));
        send_reading(reading(KIND_STEP, 1'b1, 16'sd100, SIDE_UNKNOWN, 16'sd500));
        send_reading(reading(KIND_STEP, 1'b1, -16'sd100, SIDE_UNKNOWN, 16'sd500));

        // Random phases: two per idling pattern, then none, each with fresh settings.
        // A long receiver hold-off is thrown in while the sender keeps offering.
        for (int p = 0; p < 6; p++) begin
            settle();
            load_settings(phase_settings(p));
            snd_idle_pct  = (p < 2) ? 19 : (p < 4) ? 57 : 0;
            rcv_stall_pct = (p < 2) ? 57 : (p < 4) ? 19 : 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ((p == 1 || p == 3 || p == 5) && i == 120) hold_asked++;
                send_reading(random_reading());
            end
        end

        settle();
        repeat (10) @(posedge aclk);

        $display("Covered %0d sensor transactions: directed edge cases, extreme and random",
                 sent);
        $display("register settings, three idling patterns and long receiver hold-offs.");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #RUN_LIMIT;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
